/* rtl/cci_pkg.sv */
// shared types, constants and helper functions of the curvature curve integrator
`timescale 1ns / 1ps
`default_nettype none
package cci_pkg;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE    = 5'd0;
  localparam op_t OP_RESTART = 5'd1;
  localparam op_t OP_LIMIT   = 5'd2;
  localparam op_t OP_S1      = 5'd3;
  localparam op_t OP_K1      = 5'd4;
  localparam op_t OP_K2      = 5'd5;
  localparam op_t OP_PLO     = 5'd6;
  localparam op_t OP_PHI     = 5'd7;
  localparam op_t OP_MOD     = 5'd8;
  localparam op_t OP_FOLD    = 5'd9;
  localparam op_t OP_CORDIC  = 5'd10;
  localparam op_t OP_TXA     = 5'd11;
  localparam op_t OP_TXB     = 5'd12;
  localparam op_t OP_TYA     = 5'd13;
  localparam op_t OP_TYB     = 5'd14;
  localparam op_t OP_NY      = 5'd15;
  localparam op_t OP_INCX    = 5'd16;
  localparam op_t OP_INCY    = 5'd17;
  localparam op_t OP_COMMIT  = 5'd18;
  localparam op_t OP_LOAD    = 5'd19;
  localparam op_t OP_MODQ    = 5'd20;
  localparam op_t OP_MODR    = 5'd21;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_STEP_SIZE = 2'd0;
  localparam cfg_idx_t CFG_START_X   = 2'd1;
  localparam cfg_idx_t CFG_START_Y   = 2'd2;

  typedef struct packed {
    op_t        op;
    logic [4:0] iter;
  } cci_cmd_t;

  typedef struct packed {
    logic at_limit;
  } cci_stat_t;

  localparam int CNT_W        = 10;
  localparam int COUNT_CAP    = 1023;
  localparam int CORDIC_ITERS = 30;

  localparam logic [15:0]        STEP_RESET  = 16'd6554;
  localparam logic [26:0]        TWO_PI_U    = 27'd105414357;
  // floor(2^46 / (2*pi in Q.24)) for the quotient estimate
  localparam logic [19:0]        MOD_RECIP   = 20'd667544;
  localparam logic signed [27:0] TWO_PI_Q24  = 28'sd105414357;
  localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
  localparam logic signed [33:0] GAIN_Q30    = 34'sh0_26DD_3B6A;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sh3243F6A8;
      5'd1:  v = 34'sh1DAC6705;
      5'd2:  v = 34'sh0FADBAFC;
      5'd3:  v = 34'sh07F56EA6;
      5'd4:  v = 34'sh03FEAB76;
      5'd5:  v = 34'sh01FFD55B;
      5'd6:  v = 34'sh00FFFAAA;
      5'd7:  v = 34'sh007FFF55;
      5'd8:  v = 34'sh003FFFEA;
      5'd9:  v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      5'd24: v = 34'sh0000003F;
      5'd25: v = 34'sh0000001F;
      5'd26: v = 34'sh0000000F;
      5'd27: v = 34'sh00000008;
      5'd28: v = 34'sh00000004;
      5'd29: v = 34'sh00000002;
      default: v = 34'sh0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -67'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/cci_if.sv */
// channel interfaces: input beat, result beat and configuration write
`timescale 1ns / 1ps
`default_nettype none
interface cci_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface cci_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [9:0]         point_index;
  logic               at_limit;
  modport source (output valid, output point_x, output point_y, output point_index,
                  output at_limit, input ready);
  modport sink (input valid, input point_x, input point_y, input point_index,
                input at_limit, output ready);
endinterface

interface cci_cfg_if import cci_pkg::*;;
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/cci_datapath.sv */
// arithmetic datapath: angle, modulo reduction, cordic, tangent and point update
`timescale 1ns / 1ps
`default_nettype none
module cci_datapath import cci_pkg::*; #(
  parameter int LIMIT = 1023
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cci_cmd_t          cmd,
  output cci_stat_t              stat,
  input  wire logic              cfg_we,
  input  wire cfg_idx_t          cfg_index,
  input  wire logic [31:0]       cfg_data,
  output logic signed [31:0]     out_x,
  output logic signed [31:0]     out_y,
  output logic [CNT_W-1:0]       out_index,
  output logic                   out_lim
);

  logic [15:0]        step_size_r;
  logic signed [31:0] start_x_r, start_y_r;
  logic [CNT_W-1:0]   step_count_r;
  logic signed [31:0] tx_r, ty_r, nx_r, ny_r, last_x_r, last_y_r;
  logic               lim_r;
  logic [25:0]        s1_r;
  logic [44:0]        ksum_r;
  logic [60:0]        prod_r;
  logic [17:0]        q_r;
  logic [27:0]        rdiff_r;
  logic [26:0]        rem_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic               flip_r;
  logic signed [66:0] acc_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic [CNT_W-1:0]   out_index_r;
  logic               out_lim_r;

  logic [CNT_W:0]     n_w;
  logic [26:0]        s1_w;
  logic [25:0]        s2_w;
  logic [51:0]        sq1_w, sq2_w;
  logic [38:0]        plo_w;
  logic [37:0]        phi_w;
  logic [37:0]        qp_w;
  logic [44:0]        qm_w;
  logic [44:0]        rd_w;
  logic signed [27:0] a0_w, a1_w, a2_w;
  logic               flip_w;
  logic signed [33:0] xs_w, ys_w, at_w, c_w, sn_w, mb_w;
  logic signed [31:0] ma_w;
  logic signed [65:0] mp_w;
  logic signed [32:0] tsum_w;
  logic signed [49:0] inc_w;
  logic signed [31:0] lold_w;
  logic signed [66:0] lnew_w;

  assign stat.at_limit = (step_count_r >= CNT_W'(LIMIT));

  assign n_w   = {1'b0, step_count_r} + (CNT_W+1)'(1);
  assign s1_w  = n_w * step_size_r;
  assign s2_w  = s1_r + {10'd0, step_size_r};
  assign sq1_w = s1_r * s1_r;
  assign sq2_w = s2_w * s2_w;
  assign plo_w = ksum_r[22:0] * step_size_r;
  assign phi_w = ksum_r[44:23] * step_size_r;

  // angle modulo 2*pi: the quotient estimate from the top bits is at most
  // one short, so one compare and subtract finishes the remainder
  assign qp_w = prod_r[60:43] * MOD_RECIP;
  assign qm_w = q_r * TWO_PI_U;
  assign rd_w = {1'b0, prod_r[60:17]} - qm_w;

  // fold angle into [-pi/2, pi/2]
  always_comb begin
    a0_w   = {1'b0, rem_r};
    a1_w   = (a0_w > PI_Q24) ? a0_w - TWO_PI_Q24 : a0_w;
    a2_w   = a1_w;
    flip_w = 1'b0;
    if (a1_w > HALF_PI_Q24) begin
      a2_w   = a1_w - PI_Q24;
      flip_w = 1'b1;
    end else if (a1_w < -HALF_PI_Q24) begin
      a2_w   = a1_w + PI_Q24;
      flip_w = 1'b1;
    end
  end

  assign xs_w = x_r >>> cmd.iter;
  assign ys_w = y_r >>> cmd.iter;
  assign at_w = atan_q30(cmd.iter);
  assign c_w  = flip_r ? -x_r : x_r;
  assign sn_w = flip_r ? -y_r : y_r;

  // one shared signed multiplier for the rotation products
  always_comb begin
    case (cmd.op)
      OP_TXA: begin ma_w = tx_r; mb_w = c_w; end
      OP_TXB: begin ma_w = ty_r; mb_w = sn_w; end
      OP_TYA: begin ma_w = ty_r; mb_w = c_w; end
      default: begin ma_w = tx_r; mb_w = sn_w; end
    endcase
  end
  assign mp_w = ma_w * mb_w;

  assign tsum_w = (cmd.op == OP_INCY) ? 33'(ty_r) + 33'(ny_r) : 33'(tx_r) + 33'(nx_r);
  assign inc_w  = tsum_w * $signed({1'b0, step_size_r});
  assign lold_w = (cmd.op == OP_INCY) ? last_y_r : last_x_r;
  assign lnew_w = 67'(lold_w) + 67'(inc_w >>> 23);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r  <= STEP_RESET;
      start_x_r    <= '0;
      start_y_r    <= '0;
      step_count_r <= '0;
      tx_r         <= ONE_Q30;
      ty_r         <= '0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      lim_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_SIZE: step_size_r <= cfg_data[15:0];
          CFG_START_X:   start_x_r   <= cfg_data;
          CFG_START_Y:   start_y_r   <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_RESTART: begin
          step_count_r <= '0;
          tx_r         <= ONE_Q30;
          ty_r         <= '0;
          last_x_r     <= start_x_r;
          last_y_r     <= start_y_r;
          lim_r        <= 1'b0;
        end
        OP_LIMIT: lim_r <= 1'b1;
        OP_INCX:  last_x_r <= sat32(lnew_w);
        OP_INCY:  last_y_r <= sat32(lnew_w);
        OP_COMMIT: begin
          tx_r         <= nx_r;
          ty_r         <= ny_r;
          step_count_r <= n_w[CNT_W-1:0];
          lim_r        <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // working registers carry no reset
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_S1:  s1_r <= s1_w[25:0];
      OP_K1:  ksum_r <= {1'b0, sq1_w[51:8]};
      OP_K2:  ksum_r <= ksum_r + {1'b0, sq2_w[51:8]};
      OP_PLO: prod_r <= {22'd0, plo_w};
      OP_PHI: prod_r <= prod_r + {phi_w, 23'd0};
      OP_MODQ: q_r <= qp_w[37:20];
      OP_MODR: rdiff_r <= rd_w[27:0];
      OP_MOD: begin
        rem_r <= (rdiff_r >= {1'b0, TWO_PI_U}) ? 27'(rdiff_r - {1'b0, TWO_PI_U})
                                                : rdiff_r[26:0];
      end
      OP_FOLD: begin
        x_r    <= GAIN_Q30;
        y_r    <= '0;
        z_r    <= {a2_w, 6'd0};
        flip_r <= flip_w;
      end
      OP_CORDIC: begin
        if (z_r >= 0) begin
          x_r <= x_r - ys_w;
          y_r <= y_r + xs_w;
          z_r <= z_r - at_w;
        end else begin
          x_r <= x_r + ys_w;
          y_r <= y_r - xs_w;
          z_r <= z_r + at_w;
        end
      end
      OP_TXA: acc_r <= 67'(mp_w);
      OP_TXB: acc_r <= acc_r - 67'(mp_w);
      OP_TYA: begin
        nx_r  <= sat32(acc_r >>> 30);
        acc_r <= 67'(mp_w);
      end
      OP_TYB: acc_r <= acc_r + 67'(mp_w);
      OP_NY:  ny_r <= sat32(acc_r >>> 30);
      OP_LOAD: begin
        out_x_r     <= last_x_r;
        out_y_r     <= last_y_r;
        out_index_r <= step_count_r;
        out_lim_r   <= lim_r;
      end
      default: ;
    endcase
  end

  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_index = out_index_r;
  assign out_lim   = out_lim_r;

endmodule
`default_nettype wire

/* rtl/cci_ctrl.sv */
// controller: sequences one step through the datapath and owns the handshakes
`timescale 1ns / 1ps
`default_nettype none
module cci_ctrl import cci_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_restart,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire cci_stat_t stat,
  output cci_cmd_t       cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_S1     = 5'd1;
  localparam logic [4:0] S_K1     = 5'd2;
  localparam logic [4:0] S_K2     = 5'd3;
  localparam logic [4:0] S_PLO    = 5'd4;
  localparam logic [4:0] S_PHI    = 5'd5;
  localparam logic [4:0] S_MODQ   = 5'd6;
  localparam logic [4:0] S_MODR   = 5'd7;
  localparam logic [4:0] S_MOD    = 5'd8;
  localparam logic [4:0] S_FOLD   = 5'd9;
  localparam logic [4:0] S_CORDIC = 5'd10;
  localparam logic [4:0] S_TXA    = 5'd11;
  localparam logic [4:0] S_TXB    = 5'd12;
  localparam logic [4:0] S_TYA    = 5'd13;
  localparam logic [4:0] S_TYB    = 5'd14;
  localparam logic [4:0] S_NY     = 5'd15;
  localparam logic [4:0] S_INCX   = 5'd16;
  localparam logic [4:0] S_INCY   = 5'd17;
  localparam logic [4:0] S_COMMIT = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic [5:0] iter_r, iter_nxt;
  logic       out_valid_r, out_valid_nxt;
  op_t        op_w;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cmd.op    = op_w;
  assign cmd.iter  = iter_r[4:0];

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op_w          = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            op_w      = OP_RESTART;
            state_nxt = S_DONE;
          end else if (stat.at_limit) begin
            op_w      = OP_LIMIT;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_S1;
          end
        end
      end
      S_S1:   begin op_w = OP_S1;   state_nxt = S_K1; end
      S_K1:   begin op_w = OP_K1;   state_nxt = S_K2; end
      S_K2:   begin op_w = OP_K2;   state_nxt = S_PLO; end
      S_PLO:  begin op_w = OP_PLO;  state_nxt = S_PHI; end
      S_PHI:  begin op_w = OP_PHI;  state_nxt = S_MODQ; end
      S_MODQ: begin op_w = OP_MODQ; state_nxt = S_MODR; end
      S_MODR: begin op_w = OP_MODR; state_nxt = S_MOD; end
      S_MOD:  begin op_w = OP_MOD;  state_nxt = S_FOLD; end
      S_FOLD: begin
        op_w      = OP_FOLD;
        iter_nxt  = '0;
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        op_w     = OP_CORDIC;
        iter_nxt = iter_r + 6'd1;
        if (iter_r == 6'(CORDIC_ITERS - 1)) state_nxt = S_TXA;
      end
      S_TXA:    begin op_w = OP_TXA;    state_nxt = S_TXB; end
      S_TXB:    begin op_w = OP_TXB;    state_nxt = S_TYA; end
      S_TYA:    begin op_w = OP_TYA;    state_nxt = S_TYB; end
      S_TYB:    begin op_w = OP_TYB;    state_nxt = S_NY; end
      S_NY:     begin op_w = OP_NY;     state_nxt = S_INCX; end
      S_INCX:   begin op_w = OP_INCX;   state_nxt = S_INCY; end
      S_INCY:   begin op_w = OP_INCY;   state_nxt = S_COMMIT; end
      S_COMMIT: begin op_w = OP_COMMIT; state_nxt = S_DONE; end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          op_w          = OP_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/curvature_curve_integrator.sv */
// top level of the curvature curve integrator
`timescale 1ns / 1ps
`default_nettype none
// Rebuilds a plane curve from curvature k(s) = s*s, one point per input beat.
// A beat with restart = 1 returns to (start_x, start_y) with tangent (1,0)
// and emits that point with index 0; a beat with restart = 0 advances one
// arc-length step of step_size (Q0.16) and emits the new point in Q8.24.
// Once the index reaches the step limit (MAX_STEPS, capped at 1023), an
// advance holds all state and emits the last point with at_limit set.
// Sequence: a restart or a refused advance takes the accept and the result
// load; a normal advance takes the accept, the angle (two squarings and a
// two-part product), the reduction modulo 2*pi (reciprocal quotient
// estimate, remainder, one correction), the quadrant fold, 30 cordic
// iterations, the tangent rotation through one shared multiplier, the
// point update, the commit and the load. Input is taken only when the
// sequencer is idle; the result register lets the next beat in while a
// finished result waits, and only that next result's load waits for the
// receiver.
// Configuration writes are always taken (cfg ready is tied high); write
// them only while no beat is in flight. Start registers take effect at
// the next restart.
module curvature_curve_integrator import cci_pkg::*; #(
  parameter int MAX_STEPS = 1023
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cci_in_if.sink    in_ch,
  cci_out_if.source out_ch,
  cci_cfg_if.sink   cfg_ch
);

  // effective limit is bounded by the 10 bit index
  localparam int LIMIT = (MAX_STEPS > COUNT_CAP) ? COUNT_CAP : MAX_STEPS;

  cci_cmd_t  cmd;
  cci_stat_t stat;

  // config beats always accepted
  assign cfg_ch.ready = 1'b1;

  cci_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  cci_datapath #(.LIMIT(LIMIT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_x     (out_ch.point_x),
    .out_y     (out_ch.point_y),
    .out_index (out_ch.point_index),
    .out_lim   (out_ch.at_limit)
  );

endmodule
`default_nettype wire

/* rtl/cci_checker.sv */
// port-level checker for the curvature curve integrator and its bind
`timescale 1ns / 1ps
`default_nettype none
module cci_checker #(
  parameter int MAX_STEPS = 1023
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] point_x,
  input wire logic [31:0] point_y,
  input wire logic [9:0]  point_index,
  input wire logic        at_limit
);

  localparam int LIMIT = (MAX_STEPS > 1023) ? 1023 : MAX_STEPS;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
      && $stable(point_index) && $stable(at_limit))
    else $error("result beat changed while stalled");

  // a refused advance reports the limit index
  a_limit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && at_limit |-> point_index == 10'(LIMIT))
    else $error("at_limit with wrong index");

  // one beat at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // a new result is loaded only while the sequencer is busy
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

bind curvature_curve_integrator cci_checker #(.MAX_STEPS(MAX_STEPS)) u_cci_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .point_x     (out_ch.point_x),
  .point_y     (out_ch.point_y),
  .point_index (out_ch.point_index),
  .at_limit    (out_ch.at_limit)
);
`default_nettype wire

/* dv/cci_point_checker.sv */
// watches the channels of the curvature curve integrator, predicts each point and compares
`timescale 1ns / 1ps
module cci_point_checker import cci_pkg::*; #(
  parameter int MAX_STEPS = 1023
) (
  input  logic clk,
  input  logic rst_n,
  cci_in_if    in_ch,
  cci_out_if   out_ch,
  cci_cfg_if   cfg_ch,
  output int   mismatches,
  output int   points_due,
  output int   points_seen,
  output int   limit_points
);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [9:0]         idx;
    logic               lim;
  } curve_point_t;

  localparam longint STEP_LIMIT = (MAX_STEPS > COUNT_CAP) ? COUNT_CAP : MAX_STEPS;
  localparam longint ARCTAN [30] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002
  };

  curve_point_t points_q[$];

  logic [15:0]        eps;
  logic signed [31:0] home_x, home_y;
  longint             steps, tan_x, tan_y, pos_x, pos_y;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // cordic rotation of gain-scaled (1,0) by an angle in [0, 2*pi) Q.24
  task automatic rotate_unit(input longint a, output longint c, output longint s);
    longint x, y, z, xs, ys;
    bit     flip;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    if (a > PI_Q24) a -= TWO_PI_Q24;
    if (a > HALF_PI_Q24) begin
      a -= PI_Q24;
      flip = 1;
    end else if (a < -HALF_PI_Q24) begin
      a += PI_Q24;
      flip = 1;
    end
    z = a * 64;
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ARCTAN[i];
      end else begin
        x += ys; y -= xs; z += ARCTAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_point(input logic restart);
    longint unsigned e, n, s1, s2, k1, k2, ang;
    longint c, s, nx, ny;
    curve_point_t p;
    e = eps;
    p.lim = 0;
    if (restart) begin
      steps = 0; tan_x = ONE_Q30; tan_y = 0; pos_x = home_x; pos_y = home_y;
    end else if (steps >= STEP_LIMIT) begin
      p.lim = 1;
    end else begin
      n = steps + 1;
      s1 = n * e;
      s2 = (n + 1) * e;
      k1 = (s1 * s1) >> 8;
      k2 = (s2 * s2) >> 8;
      ang = (((k1 + k2) * e) >> 17) % 64'd105414357;
      rotate_unit(longint'(ang), c, s);
      nx = clamp32((tan_x * c - tan_y * s) >>> 30);
      ny = clamp32((tan_y * c + tan_x * s) >>> 30);
      pos_x = clamp32(pos_x + (((tan_x + nx) * longint'(e)) >>> 23));
      pos_y = clamp32(pos_y + (((tan_y + ny) * longint'(e)) >>> 23));
      tan_x = nx;
      tan_y = ny;
      steps = n;
    end
    p.px = pos_x[31:0];
    p.py = pos_y[31:0];
    p.idx = steps[9:0];
    points_q = {points_q, p};
  endtask

  always @(posedge clk) begin
    curve_point_t want;
    if (!rst_n) begin
      eps <= STEP_RESET;
      home_x <= 0; home_y <= 0;
      steps = 0; tan_x = ONE_Q30; tan_y = 0; pos_x = 0; pos_y = 0;
      points_q.delete();
      mismatches <= 0; points_seen <= 0; limit_points <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_STEP_SIZE: eps <= cfg_ch.data[15:0];
          CFG_START_X:   home_x <= cfg_ch.data;
          CFG_START_Y:   home_y <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict_point(in_ch.restart);
      if (out_ch.valid && out_ch.ready) begin
        points_seen <= points_seen + 1;
        if (out_ch.at_limit) limit_points <= limit_points + 1;
        if (points_q.size() == 0) begin
          if (mismatches < 10) $display("%0t: point with nothing pending", $realtime);
          mismatches <= mismatches + 1;
        end else begin
          want = points_q.pop_front();
          if (out_ch.point_x !== want.px || out_ch.point_y !== want.py ||
              out_ch.point_index !== want.idx || out_ch.at_limit !== want.lim) begin
            if (mismatches < 10) begin
              $display("%0t: point mismatch exp x=%h y=%h idx=%0d lim=%b",
                       $realtime, want.px, want.py, want.idx, want.lim);
              $display("%0t:                got x=%h y=%h idx=%0d lim=%b",
                       $realtime, out_ch.point_x, out_ch.point_y, out_ch.point_index,
                       out_ch.at_limit);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    points_due <= points_q.size();
  end

endmodule

/* dv/tb_curvature_curve_integrator.sv */
// stimulus and verdict for the curvature curve integrator
`timescale 1ns / 1ps
module tb_curvature_curve_integrator;
  import cci_pkg::*;

  logic clk;
  logic rst_n;
  int   mismatches, points_due, points_seen, limit_points;
  int   send_idle_pct, recv_stall_pct;
  int   beats_sent;

  cci_in_if  in_ch ();
  cci_out_if out_ch ();
  cci_cfg_if cfg_ch ();

  curvature_curve_integrator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  cci_point_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .mismatches(mismatches), .points_due(points_due), .points_seen(points_seen),
    .limit_points(limit_points)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(100_000_000);
    $display("FAIL");
    $finish;
  end

  // receiver stalls decided once per cycle at the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input beat; valid stays high straight into the next beat when no gap is drawn
  task automatic send_beat(input logic restart);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 0;
      in_ch.restart = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.restart = restart;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // wait for every pending point plus a margin longer than one advance
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 0;
    do @(posedge clk); while (points_due != 0);
    repeat (100) @(posedge clk);
  endtask

  // register writes only with the block idle
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid = 1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  task automatic set_curve(input logic [15:0] eps, input logic [31:0] sx, input logic [31:0] sy);
    drain();
    write_reg(CFG_STEP_SIZE, {16'($urandom_range(16'hFFFF)), eps});
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
  endtask

  // mostly long advance runs from a restart, with the odd restart mid-run
  task automatic random_phase(input int beats, input int idle_pct, input int stall_pct);
    logic [15:0] eps;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    case ($urandom_range(3))
      0: eps = 16'hFFFF;
      1: eps = 16'($urandom_range(16'hFFFF));
      default: eps = 16'($urandom_range(8000, 1));
    endcase
    set_curve(eps, $urandom, $urandom);
    send_beat(1);
    repeat (beats) send_beat($urandom_range(99) < 4);
  endtask

  initial begin
    rst_n = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    beats_sent = 0;
    in_ch.valid = 0;
    in_ch.restart = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_STEP_SIZE;
    cfg_ch.data = 0;
    out_ch.ready = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reset defaults, advancing before any restart, then a restart
    repeat (3) send_beat(0);
    send_beat(1);
    repeat (2) send_beat(0);
    // largest step from the extreme corners, pushing points into saturation
    set_curve(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(1);
    repeat (5) send_beat(0);
    set_curve(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(1);
    repeat (3) send_beat(0);
    // zero step keeps the point still while the index moves
    set_curve(16'h0000, 32'h0123_4567, 32'hFEDC_BA98);
    send_beat(1);
    repeat (3) send_beat(0);
    // smallest nonzero step; a start write alone must not move the point
    set_curve(16'h0001, 32'h0, 32'h0);
    send_beat(1);
    send_beat(0);
    drain();
    write_reg(CFG_START_X, 32'h0500_0000);
    send_beat(0);
    send_beat(1);

    // one long run through the step limit, then held advances and a restart
    set_curve(16'd300, $urandom, $urandom);
    send_beat(1);
    repeat (1030) send_beat(0);
    send_beat(1);
    send_beat(0);

    random_phase(180, 0, 0);
    random_phase(180, 51, 0);
    random_phase(180, 0, 51);
    random_phase(180, 11, 11);
    random_phase(60, 51, 51);

    drain();
    $display("sent %0d beats, checked %0d points, %0d of them held at the step limit",
             beats_sent, points_seen, limit_points);
    $display("step sizes from 0 to 65535, start points at both extremes, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
